[sv/bnf_pkg.sv]
// ----------------------------------------------------------------------------
// bnf_pkg
// Shared types and constants of the next-fit block allocator.
// ----------------------------------------------------------------------------
package bnf_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT  = 2'd1;

    localparam logic [2:0] OP_LOAD_GROUP    = 3'd0;
    localparam logic [2:0] OP_INIT_POINTER  = 3'd1;
    localparam logic [2:0] OP_RESERVE_RANGE = 3'd2;
    localparam logic [2:0] OP_CLAIM         = 3'd3;
    localparam logic [2:0] OP_ALLOCATE      = 3'd4;

    // Reserve rule: a tenth above this total, half at or below it
    localparam logic [16:0] RESERVE_SPLIT = 17'd10240;
    // ceil(2^20 / 10): exact quotient by ten for any 17-bit total
    localparam logic [16:0] RECIP_TEN     = 17'd104858;
    localparam int          RECIP_SHIFT   = 20;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  group_index;
        logic [15:0] first_block;
        logic [16:0] block_count;
    } req_t;

    typedef struct packed {
        logic [15:0] block;
        logic        status;
        logic        already_claimed;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_INIT_RD,
        ST_INIT_CALC,
        ST_RSV_RD,
        ST_RSV_WR,
        ST_CLM_RD,
        ST_CLM_WR,
        ST_ALC_GRP,
        ST_ALC_RANGE,
        ST_ALC_RD,
        ST_ALC_CHK,
        ST_DONE
    } state_t;

endpackage

[sv/bnf_if.sv]
// ----------------------------------------------------------------------------
// bnf_req_if / bnf_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface bnf_req_if;
    logic          valid;
    logic          ready;
    bnf_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bnf_rsp_if;
    logic          valid;
    logic          ready;
    bnf_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/bitmap_next_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_next_fit_block_allocator
// Next-fit block allocator: used-block bitmap in RAM, group range table in
// RAM, next-fit pointer and configuration in registers.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   req.valid/ready    op, group_index, first_block, block_count
//  rsp      out  rsp.valid/ready    block, status, already_claimed
//  cfg      in   cfg_we             cfg_index, cfg_data (no read-back)
//
//  One item at a time; a bitmap word access is a read, followed by a write
//  back where bits are set, through the single-port-pair bitmap RAM.
//  load_group writes one group table entry; unknown ops go straight to the result.
//  claim reads and writes back one word, or only reads it past the bound.
//  init_pointer reads the last group entry and sets the pointer, or zeroes it with
//  no groups. reserve_range reads and writes back each word touched. allocate visits
//  groups and scans bitmap words until a free block is found, so its time follows bitmap fill.
//  After reset the bitmap is swept to zero, one word per cycle, over all
//  min(ceil(BLOCK_LIMIT/64), 1024) words; req.ready stays low meanwhile.
//  A finished result waits in the output register; the next item is taken
//  while it waits, and only the following result stalls until rsp.ready.
// ----------------------------------------------------------------------------
module bitmap_next_fit_block_allocator #(
    parameter int BLOCK_LIMIT = 65536,
    parameter int MAX_GROUPS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bnf_req_if.sink                        req,
    bnf_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [bnf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bnf_pkg::CFG_DATA_W-1:0] cfg_data
);

    import bnf_pkg::*;

    // Block numbers are 16 bits, so no more than 1024 words are ever reached
    localparam int MAP_WORDS = (BLOCK_LIMIT + 63) / 64;
    localparam int MAP_DEPTH = (MAP_WORDS < 1024) ? MAP_WORDS : 1024;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int GRP_AW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int BLK_CAP   = (BLOCK_LIMIT < 65536) ? BLOCK_LIMIT : 65536;

    // Control and configuration
    state_t        state_reg, state_next;
    logic [16:0]   total_reg;
    logic [4:0]    gcount_reg;
    logic [15:0]   ptr_reg, ptr_next;
    logic [MAP_AW-1:0] clr_reg, clr_next;
    logic [4:0]    g_reg, g_next;
    logic          out_valid_reg, out_valid_next;

    // Item working registers
    req_t          item_reg, item_next;
    logic [16:0]   cur_reg, cur_next;
    logic [16:0]   hi_reg, hi_next;
    logic [16:0]   rsv_reg, rsv_next;
    rsp_t          res_reg, res_next;
    rsp_t          out_reg, out_next;

    // Derived values
    logic [16:0]   bound;
    logic [4:0]    ngroups;
    logic [16:0]   base;
    logic [16:0]   base_inc;
    logic [16:0]   span;
    logic [33:0]   tenth_prod;
    logic [17:0]   grp_end;
    logic [17:0]   init_diff;
    logic [16:0]   alc_lo;
    logic [16:0]   alc_hi;

    // Memory ports
    logic              map_we;
    logic [MAP_AW-1:0] map_waddr, map_raddr;
    logic [63:0]       map_wdata, map_rdata;
    logic              grp_we;
    logic [GRP_AW-1:0] grp_waddr, grp_raddr;
    logic [32:0]       grp_wdata, grp_rdata;

    logic [63:0]       win_mask;
    logic              win_found;
    logic [5:0]        win_pos;

    logic              out_load;

    bnf_ram #(.WIDTH(64), .DEPTH(MAP_DEPTH)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Group table entry: {length, start}
    bnf_ram #(.WIDTH(33), .DEPTH(MAX_GROUPS)) u_grp_ram (
        .clk   (clk),
        .we    (grp_we),
        .waddr (grp_waddr),
        .wdata (grp_wdata),
        .raddr (grp_raddr),
        .rdata (grp_rdata)
    );

    bnf_word_find u_find (
        .word   (map_rdata),
        .lo_bit (cur_reg[5:0]),
        .span   (span),
        .mask   (win_mask),
        .found  (win_found),
        .pos    (win_pos)
    );

    always_comb
    begin
        bound      = (32'(total_reg) > BLK_CAP) ? 17'(BLK_CAP) : total_reg;
        ngroups    = (32'(gcount_reg) > MAX_GROUPS) ? 5'(MAX_GROUPS) : gcount_reg;
        base       = {cur_reg[16:6], 6'd0};
        base_inc   = base + 17'd64;
        span       = hi_reg - base;
        tenth_prod = total_reg * RECIP_TEN;
        grp_end    = {2'b00, grp_rdata[15:0]} + {1'b0, grp_rdata[32:16]};
        init_diff  = (grp_end > {1'b0, rsv_reg}) ? grp_end - {1'b0, rsv_reg} : 18'd0;
        alc_lo     = (grp_rdata[15:0] <= ptr_reg) ? {1'b0, ptr_reg} + 17'd1
                                                  : {1'b0, grp_rdata[15:0]};
        alc_hi     = (grp_end > {1'b0, bound}) ? bound : grp_end[16:0];
        out_load   = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == MAP_AW'(MAP_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.data.op)
                        OP_LOAD_GROUP:    state_next = ST_LOAD;
                        OP_INIT_POINTER:  state_next = ST_INIT_RD;
                        OP_RESERVE_RANGE: state_next = ST_RSV_RD;
                        OP_CLAIM:         state_next = ST_CLM_RD;
                        OP_ALLOCATE:      state_next = ST_ALC_GRP;
                        default:          state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOAD:      state_next = ST_DONE;
            ST_INIT_RD:   state_next = (ngroups == 5'd0) ? ST_DONE : ST_INIT_CALC;
            ST_INIT_CALC: state_next = ST_DONE;
            ST_RSV_RD:    state_next = (cur_reg < hi_reg) ? ST_RSV_WR : ST_DONE;
            ST_RSV_WR:    state_next = ST_RSV_RD;
            ST_CLM_RD:
            begin
                state_next = ({1'b0, item_reg.first_block} < bound) ? ST_CLM_WR : ST_DONE;
            end
            ST_CLM_WR:    state_next = ST_DONE;
            ST_ALC_GRP:   state_next = (g_reg < ngroups) ? ST_ALC_RANGE : ST_DONE;
            ST_ALC_RANGE: state_next = ST_ALC_RD;
            ST_ALC_RD:    state_next = (cur_reg < hi_reg) ? ST_ALC_CHK : ST_ALC_GRP;
            ST_ALC_CHK:   state_next = win_found ? ST_DONE : ST_ALC_RD;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshakes and memory ports
    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
        rsp.valid = out_valid_reg;
        rsp.data  = out_reg;

        map_we    = 1'b0;
        map_waddr = MAP_AW'(cur_reg[15:6]);
        map_wdata = map_rdata;
        map_raddr = MAP_AW'(cur_reg[15:6]);
        grp_we    = 1'b0;
        grp_waddr = GRP_AW'(item_reg.group_index);
        grp_wdata = {item_reg.block_count, item_reg.first_block};
        grp_raddr = GRP_AW'(g_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = 64'd0;
            end
            ST_LOAD:
            begin
                grp_we = (32'(item_reg.group_index) < MAX_GROUPS);
            end
            ST_INIT_RD:
            begin
                grp_raddr = GRP_AW'(ngroups - 5'd1);
            end
            ST_RSV_WR:
            begin
                map_we    = 1'b1;
                map_wdata = map_rdata | win_mask;
            end
            ST_CLM_RD:
            begin
                map_raddr = MAP_AW'(item_reg.first_block[15:6]);
            end
            ST_CLM_WR:
            begin
                map_we    = 1'b1;
                map_waddr = MAP_AW'(item_reg.first_block[15:6]);
                map_wdata = map_rdata | (64'd1 << item_reg.first_block[5:0]);
            end
            ST_ALC_CHK:
            begin
                map_we    = win_found;
                map_wdata = map_rdata | (64'd1 << win_pos);
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        ptr_next       = ptr_reg;
        clr_next       = clr_reg + MAP_AW'(1);
        g_next         = g_reg;
        item_next      = item_reg;
        cur_next       = cur_reg;
        hi_next        = hi_reg;
        rsv_next       = rsv_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Latch the item and set up the range bound for reserve_range
                item_next = req.data;
                res_next  = '0;
                g_next    = 5'd0;
                cur_next  = {1'b0, req.data.first_block};
                hi_next   = ({2'b00, req.data.first_block}
                             + {1'b0, req.data.block_count} > {1'b0, bound})
                            ? bound
                            : 17'({2'b00, req.data.first_block}
                                  + {1'b0, req.data.block_count});
            end
            ST_INIT_RD:
            begin
                // A 17-bit total keeps a tenth far below 262144: no cap needed
                rsv_next = (total_reg > RESERVE_SPLIT)
                           ? 17'(tenth_prod >> RECIP_SHIFT)
                           : {1'b0, total_reg[16:1]};
                if (ngroups == 5'd0)
                begin
                    ptr_next = 16'd0;
                end
            end
            ST_INIT_CALC:
            begin
                ptr_next = (init_diff > 18'h0FFFF) ? 16'hFFFF : init_diff[15:0];
            end
            ST_RSV_WR:
            begin
                cur_next = base_inc;
            end
            ST_CLM_WR:
            begin
                res_next.already_claimed = map_rdata[item_reg.first_block[5:0]];
            end
            ST_ALC_GRP:
            begin
                if (g_reg >= ngroups)
                begin
                    res_next.status = 1'b1;
                end
            end
            ST_ALC_RANGE:
            begin
                cur_next = alc_lo;
                hi_next  = alc_hi;
                g_next   = g_reg + 5'd1;
            end
            ST_ALC_CHK:
            begin
                if (win_found)
                begin
                    ptr_next       = {cur_reg[15:6], win_pos};
                    res_next.block = {cur_reg[15:6], win_pos};
                end
                else
                begin
                    cur_next = base_inc;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            total_reg     <= 17'd65536;
            gcount_reg    <= 5'd0;
            ptr_reg       <= 16'd0;
            clr_reg       <= '0;
            g_reg         <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            clr_reg       <= clr_next;
            g_reg         <= g_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TOTAL_BLOCKS: total_reg  <= cfg_data;
                    CFG_GROUP_COUNT:  gcount_reg <= cfg_data[4:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cur_reg  <= cur_next;
        hi_reg   <= hi_next;
        rsv_reg  <= rsv_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // A result appears only after the item has finished its work
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == ST_DONE))
        else $error("result shown without a finished item");

    // The pointer moves only on a successful allocate or on init_pointer
    a_ptr_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (ptr_reg != $past(ptr_reg)) |->
            ($past(state_reg == ST_ALC_CHK) || $past(state_reg == ST_INIT_CALC)
             || $past(state_reg == ST_INIT_RD)))
        else $error("next-fit pointer changed outside allocate or init");

    // No item is taken and only zeros are written while the bitmap clear sweep runs
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!map_we || map_wdata == 64'd0) && !req.ready)
        else $error("item taken or bitmap set during clear sweep");

    // An allocated block never lies at or below the pointer it started from
    a_alloc_above_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALC_CHK && win_found) |=> (ptr_reg > $past(ptr_reg)))
        else $error("allocate returned a block not above the pointer");

endmodule

[sv/bnf_ram.sv]
// ----------------------------------------------------------------------------
// bnf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bnf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/bnf_word_find.sv]
// ----------------------------------------------------------------------------
// bnf_word_find
// Builds the bit window of one bitmap word and finds its lowest free bit.
// ----------------------------------------------------------------------------
module bnf_word_find (
    input  logic [63:0] word,
    input  logic [5:0]  lo_bit,
    input  logic [16:0] span,
    output logic [63:0] mask,
    output logic        found,
    output logic [5:0]  pos
);

    logic [63:0] free_bits;

    always_comb
    begin
        mask = {64{1'b1}} << lo_bit;
        if (span < 17'd64)
        begin
            mask = mask & ~({64{1'b1}} << span[5:0]);
        end
        free_bits = ~word & mask;
        found     = |free_bits;
        pos       = 6'd0;
        for (int i = 63; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                pos = 6'(i);
            end
        end
    end

endmodule
